### hw/rtl/sss_pkg.sv
package sss_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_CHARS   = 4;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int KEY_W  = 8 * KEY_CHARS;
  localparam int WORD_W = (KEY_W < 32) ? KEY_W : 32;

  localparam int IDX_W  = 8;
  localparam int POS_W  = 8;
  localparam int CFG_W  = 9;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } sss_result_t;

endpackage

### hw/rtl/sss_ram.sv
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/sss_search.sv
module sss_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [sss_pkg::WORD_W-1:0]  key_i,
  input  logic [sss_pkg::CNT_W-1:0]   count_i,
  output logic [sss_pkg::ADDR_W-1:0]  ram_addr_o,
  input  logic [sss_pkg::WORD_W-1:0]  ram_rdata_i,
  output logic                        busy_o,
  output logic                        res_valid_o,
  output sss_pkg::sss_result_t        res_o,
  input  logic                        res_take_i
);

  import sss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PICK,
    S_CHECK,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hip1_r, hip1_nxt;
  logic [CNT_W-1:0]   mid_r, mid_nxt;
  logic [CNT_W-1:0]   dist_r, dist_nxt;
  logic [CNT_W-1:0]   cand_r, cand_nxt;
  logic               side_r, side_nxt;
  logic               right_r, right_nxt;
  logic [WORD_W-1:0]  key_r, key_nxt;
  sss_result_t        res_r, res_nxt;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   room_left;
  logic [CNT_W:0]     right_sum;
  logic               left_ok;
  logic               right_ok;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hip1_r} - {{CNT_W{1'b0}}, 1'b1};
  assign room_left = mid_r - lo_r;
  assign left_ok   = (dist_r <= room_left);
  assign right_sum = {1'b0, mid_r} + {1'b0, dist_r};
  assign right_ok  = (right_sum < {1'b0, hip1_r});

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hip1_nxt  = hip1_r;
    mid_nxt   = mid_r;
    dist_nxt  = dist_r;
    cand_nxt  = cand_r;
    side_nxt  = side_r;
    right_nxt = right_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          lo_nxt    = '0;
          hip1_nxt  = count_i;
          key_nxt   = key_i;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (lo_r >= hip1_r) begin
          res_nxt   = '{found: 1'b0, position: '0};
          state_nxt = S_DONE;
        end else begin
          mid_nxt   = mid_sum[CNT_W:1];
          dist_nxt  = '0;
          side_nxt  = 1'b0;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (!side_r && left_ok) begin
          cand_nxt  = mid_r - dist_r;
          right_nxt = 1'b0;
          state_nxt = S_CHECK;
        end else if (right_ok) begin
          cand_nxt  = right_sum[CNT_W-1:0];
          right_nxt = 1'b1;
          state_nxt = S_CHECK;
        end else if (left_ok) begin
          dist_nxt = dist_r + 1'b1;
          side_nxt = 1'b0;
        end else begin
          res_nxt   = '{found: 1'b0, position: '0};
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        if (ram_rdata_i == '0) begin
          if (dist_r == '0) begin
            dist_nxt = {{(CNT_W-1){1'b0}}, 1'b1};
            side_nxt = 1'b0;
          end else if (!right_r) begin
            side_nxt = 1'b1;
          end else begin
            dist_nxt = dist_r + 1'b1;
            side_nxt = 1'b0;
          end
          state_nxt = S_PICK;
        end else if (ram_rdata_i == key_r) begin
          res_nxt   = '{found: 1'b1, position: POS_W'(cand_r)};
          state_nxt = S_DONE;
        end else if (ram_rdata_i > key_r) begin
          hip1_nxt  = cand_r;
          state_nxt = S_START;
        end else begin
          lo_nxt    = cand_r + 1'b1;
          state_nxt = S_START;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r    <= lo_nxt;
    hip1_r  <= hip1_nxt;
    mid_r   <= mid_nxt;
    dist_r  <= dist_nxt;
    cand_r  <= cand_nxt;
    side_r  <= side_nxt;
    right_r <= right_nxt;
    key_r   <= key_nxt;
    res_r   <= res_nxt;
  end

  assign ram_addr_o  = cand_nxt[ADDR_W-1:0];
  assign busy_o      = (state_r != S_IDLE);
  assign res_valid_o = (state_r == S_DONE);
  assign res_o       = res_r;

endmodule

### hw/rtl/sparse_sorted_string_search.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_command, in_entry_index, in_key_word
// out      output     out_valid/out_stall out_found, out_position
// cfg      input      cfg_valid/cfg_ready cfg_data (entry_count)
//
// A search loads the key and entry count, then per range step forms the midpoint
// and, per table entry probed, puts out the address and then compares the
// registered table read; a step with no probe follows when the scan past empty
// entries runs out on the right, and a last step hands the result to the output
// register. A search lasts longer when many empty entries sit next to the probes;
// the single table read port, which writes share, allows one probe at a time.
// Reset is synchronous and active low and clears the control state, the output
// valid and the entry count; table contents are not cleared. A finished result
// waits in the output register while out_stall is high; the next search may run
// meanwhile, and in_stall stays high from its finish until that register is free.
module sparse_sorted_string_search (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [sss_pkg::IDX_W-1:0] in_entry_index,
  input  logic [31:0]               in_key_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [sss_pkg::POS_W-1:0] out_position,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sss_pkg::CFG_W-1:0] cfg_data
);

  import sss_pkg::*;

  logic [CFG_W-1:0]  entry_count_r;
  logic [CNT_W-1:0]  search_count;
  logic              in_xfer;
  logic              busy;
  logic              start;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ADDR_W-1:0] search_addr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] key_word;
  logic              res_valid;
  logic              res_take;
  sss_result_t       res;
  logic              out_valid_r;
  sss_result_t       out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_data;
    end
  end

  assign search_count = (32'(entry_count_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(entry_count_r);

  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign key_word = WORD_W'(in_key_word);
  assign start    = in_xfer && (in_command == CMD_SEARCH);
  assign ram_we   = in_xfer && (in_command == CMD_WRITE)
                    && (32'(in_entry_index) < TABLE_DEPTH);
  assign ram_addr = (in_xfer && (in_command == CMD_WRITE)) ? ADDR_W'(in_entry_index)
                                                           : search_addr;

  sss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (key_word),
    .rdata (ram_rdata)
  );

  sss_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .key_i       (key_word),
    .count_i     (search_count),
    .ram_addr_o  (search_addr),
    .ram_rdata_i (ram_rdata),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_res_r.found;
  assign out_position = out_res_r.position;

endmodule
